[hdl/fcfw_pkg.sv]
`default_nettype none
package fcfw_pkg;

  // store geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_BITS  = $clog2(DEPTH);
  localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
  localparam int X_BITS     = $clog2(MAX_WIDTH);
  localparam int Y_BITS     = $clog2(MAX_HEIGHT);

  // fixed field widths
  localparam int CFG_BITS    = 10;
  localparam int KIND_BITS   = 3;
  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 16;
  localparam int COUNT_BITS  = 19;
  localparam int INDEX_BITS  = 32;
  localparam int CLIP_BITS   = COORD_BITS + 2;
  localparam int IN_BITS     = 5 * COORD_BITS + 1;
  localparam int IN_TDATA    = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = COLOR_BITS + COUNT_BITS;
  localparam int OUT_TDATA   = ((OUT_BITS + 7) / 8) * 8;

  // item kinds
  localparam logic [KIND_BITS-1:0] KIND_PIXEL  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_RECT   = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_SCREEN = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_WINDOW = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_STREAM = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_READ   = 3'd5;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 10'd240;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 10'd320;

  typedef struct packed {
    logic                  set;
    logic                  step;
    logic [COORD_BITS-1:0] org_x;
    logic [COORD_BITS-1:0] org_y;
    logic [COORD_BITS-1:0] width;
  } win_cmd_t;

  typedef struct packed {
    logic                  en;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } win_stat_t;

endpackage
`default_nettype wire

[hdl/framebuffer_clip_fill_window_writer_unit.sv]
`default_nettype none
// flow: an accepted request passes the prep, multiply and address states to the response state;
// a read also passes the read-wait state, and a rectangle or screen fill writes one pixel per
// cycle in the fill state; m_tvalid rises from the response state once the output is free
// one request at a time: the next is taken only after the last result is loaded into the output
// reset: synchronous; after reset the store is cleared one entry per cycle, and no request
// is taken until it is clear (configuration writes still are)
module framebuffer_clip_fill_window_writer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // pos_x, pos_y, rect_w, rect_h, pixel_color, swap_bytes, zero pad
  input  wire logic [fcfw_pkg::IN_TDATA-1:0]  s_tdata,
  // kind
  input  wire logic [fcfw_pkg::KIND_BITS-1:0] s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // read_color, pixels_written, zero pad
  output logic      [fcfw_pkg::OUT_TDATA-1:0] m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [fcfw_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int CB = fcfw_pkg::CLIP_BITS;
  localparam int AB = fcfw_pkg::ADDR_BITS;
  localparam int WB = fcfw_pkg::W_BITS;
  localparam int HB = fcfw_pkg::H_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_FILL  = 3'd5;
  localparam logic [2:0] ST_RWAIT = 3'd6;
  localparam logic [2:0] ST_RESP  = 3'd7;

  logic [2:0] state;

  logic [fcfw_pkg::CFG_BITS-1:0] buffer_width;
  logic [fcfw_pkg::CFG_BITS-1:0] buffer_height;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic          live;
  logic signed [CB-1:0] w_s;
  logic signed [CB-1:0] h_s;

  // request payload
  logic [fcfw_pkg::KIND_BITS-1:0]         kind;
  logic signed [fcfw_pkg::COORD_BITS-1:0] px;
  logic signed [fcfw_pkg::COORD_BITS-1:0] py;
  logic signed [fcfw_pkg::COORD_BITS-1:0] rw;
  logic signed [fcfw_pkg::COORD_BITS-1:0] rh;
  logic [fcfw_pkg::COLOR_BITS-1:0]        color;
  logic                                   swap;

  // working registers
  logic                         hit;
  logic [fcfw_pkg::X_BITS-1:0]  ax;
  logic [fcfw_pkg::Y_BITS-1:0]  ay;
  logic signed [CB-1:0]         x1;
  logic signed [CB-1:0]         y1;
  logic signed [CB-1:0]         w1;
  logic signed [CB-1:0]         h1;
  logic [WB-1:0]                fw;
  logic [HB-1:0]                fh;
  logic [AB-1:0]                prod;
  logic [AB-1:0]                fill_addr;
  logic [AB-1:0]                row_base;
  logic [WB-1:0]                fcol;
  logic [HB-1:0]                frow;
  logic [AB-1:0]                clr_addr;
  logic [fcfw_pkg::COLOR_BITS-1:0] res_color;
  logic [fcfw_pkg::COUNT_BITS-1:0] res_count;
  logic [fcfw_pkg::COLOR_BITS-1:0] out_color;
  logic [fcfw_pkg::COUNT_BITS-1:0] out_count;

  fcfw_pkg::win_cmd_t  wcmd;
  fcfw_pkg::win_stat_t wstat;

  logic                            ram_we;
  logic [AB-1:0]                   ram_waddr;
  logic [fcfw_pkg::COLOR_BITS-1:0] ram_wdata;
  logic [AB-1:0]                   addr_sum;
  logic [fcfw_pkg::COLOR_BITS-1:0] ram_rdata;

  // combinational values for the prep, multiply and address states
  logic                 pt_hit;
  logic                 st_hit;
  logic signed [CB-1:0] px_s;
  logic signed [CB-1:0] py_s;
  logic signed [CB-1:0] rw_s;
  logic signed [CB-1:0] rh_s;
  logic signed [CB-1:0] xe;
  logic signed [CB-1:0] ye;
  logic signed [CB-1:0] w2;
  logic signed [CB-1:0] h2;
  logic [fcfw_pkg::COLOR_BITS-1:0] st_color;
  logic                            fill_kind;

  assign w_eff = (int'(buffer_width) > fcfw_pkg::MAX_WIDTH) ?
                 WB'(fcfw_pkg::MAX_WIDTH) : WB'(buffer_width);
  assign h_eff = (int'(buffer_height) > fcfw_pkg::MAX_HEIGHT) ?
                 HB'(fcfw_pkg::MAX_HEIGHT) : HB'(buffer_height);
  assign live  = (w_eff != '0) && (h_eff != '0);
  assign w_s   = CB'(w_eff);
  assign h_s   = CB'(h_eff);

  assign px_s = CB'(px);
  assign py_s = CB'(py);
  assign rw_s = CB'(rw);
  assign rh_s = CB'(rh);

  assign fill_kind = (kind == fcfw_pkg::KIND_RECT) || (kind == fcfw_pkg::KIND_SCREEN);

  assign pt_hit = live && !px[fcfw_pkg::COORD_BITS-1] && !py[fcfw_pkg::COORD_BITS-1] &&
                  (px < fcfw_pkg::COORD_BITS'(w_eff)) && (py < fcfw_pkg::COORD_BITS'(h_eff));
  assign st_hit = live && wstat.en &&
                  (wstat.x < fcfw_pkg::COORD_BITS'(w_eff)) &&
                  (wstat.y < fcfw_pkg::COORD_BITS'(h_eff));

  // far-edge clip
  assign xe = x1 + w1;
  assign ye = y1 + h1;
  assign w2 = (xe > w_s) ? (w_s - x1) : w1;
  assign h2 = (ye > h_s) ? (h_s - y1) : h1;

  assign addr_sum = prod + AB'(ax);
  assign st_color = swap ? {color[7:0], color[15:8]} : color;

  assign wcmd.set   = (state == ST_PREP) && (kind == fcfw_pkg::KIND_WINDOW);
  assign wcmd.step  = (state == ST_PREP) && (kind == fcfw_pkg::KIND_STREAM) && live && wstat.en;
  assign wcmd.org_x = px;
  assign wcmd.org_y = py;
  assign wcmd.width = rw;

  fcfw_window u_window (
    .clk  (clk),
    .rst  (rst),
    .cmd  (wcmd),
    .stat (wstat)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill_addr;
    ram_wdata = color;
    unique case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      ST_ADDR: begin
        ram_waddr = addr_sum;
        if (hit && kind == fcfw_pkg::KIND_PIXEL) begin
          ram_we = 1'b1;
        end else if (hit && kind == fcfw_pkg::KIND_STREAM) begin
          ram_we    = 1'b1;
          ram_wdata = st_color;
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  fcfw_ram #(
    .WIDTH (fcfw_pkg::COLOR_BITS),
    .DEPTH (fcfw_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_sum),
    .rdata (ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(fcfw_pkg::OUT_TDATA - fcfw_pkg::OUT_BITS){1'b0}}, out_count, out_color};

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_width  <= fcfw_pkg::WIDTH_RESET;
      buffer_height <= fcfw_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == fcfw_pkg::REG_WIDTH) begin
        buffer_width <= cfg_data;
      end else begin
        buffer_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // load a new result, or drop the one just taken
      if (state == ST_RESP && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AB'(1);
          if (clr_addr == AB'(fcfw_pkg::DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            px    <= s_tdata[15:0];
            py    <= s_tdata[31:16];
            rw    <= s_tdata[47:32];
            rh    <= s_tdata[63:48];
            color <= s_tdata[79:64];
            swap  <= s_tdata[80];
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          hit   <= 1'b0;
          ax    <= px[fcfw_pkg::X_BITS-1:0];
          ay    <= py[fcfw_pkg::Y_BITS-1:0];
          x1    <= '0;
          y1    <= '0;
          w1    <= w_s;
          h1    <= h_s;
          state <= ST_MUL;
          case (kind) inside
            fcfw_pkg::KIND_PIXEL, fcfw_pkg::KIND_READ: begin
              hit <= pt_hit;
            end
            fcfw_pkg::KIND_STREAM: begin
              hit <= st_hit;
              ax  <= wstat.x[fcfw_pkg::X_BITS-1:0];
              ay  <= wstat.y[fcfw_pkg::Y_BITS-1:0];
            end
            fcfw_pkg::KIND_RECT: begin
              // negative origin shrinks the extent
              hit <= live && (rw > 0) && (rh > 0);
              x1  <= px[fcfw_pkg::COORD_BITS-1] ? '0 : px_s;
              y1  <= py[fcfw_pkg::COORD_BITS-1] ? '0 : py_s;
              w1  <= px[fcfw_pkg::COORD_BITS-1] ? (rw_s + px_s) : rw_s;
              h1  <= py[fcfw_pkg::COORD_BITS-1] ? (rh_s + py_s) : rh_s;
              ax  <= px[fcfw_pkg::COORD_BITS-1] ? '0 : px[fcfw_pkg::X_BITS-1:0];
              ay  <= py[fcfw_pkg::COORD_BITS-1] ? '0 : py[fcfw_pkg::Y_BITS-1:0];
            end
            fcfw_pkg::KIND_SCREEN: begin
              hit <= live;
              ax  <= '0;
              ay  <= '0;
            end
            default: begin
            end
          endcase
        end
        ST_MUL: begin
          prod  <= AB'(ay) * AB'(w_eff);
          fw    <= WB'(w2);
          fh    <= HB'(h2);
          if (fill_kind) begin
            hit <= hit && (w2 > 0) && (h2 > 0);
          end
          state <= ST_ADDR;
        end
        ST_ADDR: begin
          res_color <= '0;
          res_count <= '0;
          state     <= ST_RESP;
          if (hit) begin
            case (kind) inside
              fcfw_pkg::KIND_PIXEL, fcfw_pkg::KIND_STREAM: begin
                res_count <= fcfw_pkg::COUNT_BITS'(1);
              end
              fcfw_pkg::KIND_READ: begin
                state <= ST_RWAIT;
              end
              fcfw_pkg::KIND_RECT, fcfw_pkg::KIND_SCREEN: begin
                res_count <= fcfw_pkg::COUNT_BITS'(fw) * fcfw_pkg::COUNT_BITS'(fh);
                fill_addr <= addr_sum;
                row_base  <= addr_sum;
                fcol      <= '0;
                frow      <= '0;
                state     <= ST_FILL;
              end
              default: begin
              end
            endcase
          end
        end
        ST_FILL: begin
          if (fcol == fw - WB'(1)) begin
            fcol <= '0;
            if (frow == fh - HB'(1)) begin
              state <= ST_RESP;
            end else begin
              frow      <= frow + HB'(1);
              row_base  <= row_base + AB'(w_eff);
              fill_addr <= row_base + AB'(w_eff);
            end
          end else begin
            fcol      <= fcol + WB'(1);
            fill_addr <= fill_addr + AB'(1);
          end
        end
        ST_RWAIT: begin
          res_color <= ram_rdata;
          state     <= ST_RESP;
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            out_color <= res_color;
            out_count <= res_count;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/fcfw_ram.sv]
`default_nettype none
module fcfw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[hdl/fcfw_window.sv]
`default_nettype none
module fcfw_window (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fcfw_pkg::win_cmd_t cmd,
  output fcfw_pkg::win_stat_t     stat
);

  logic [fcfw_pkg::COORD_BITS-1:0] wx;
  logic [fcfw_pkg::COORD_BITS-1:0] wy;
  logic [fcfw_pkg::COORD_BITS-1:0] ww;
  // col and row track index mod width and index / width incrementally
  logic [fcfw_pkg::COORD_BITS-1:0] col;
  logic [fcfw_pkg::COORD_BITS-1:0] row;
  logic [fcfw_pkg::INDEX_BITS-1:0] idx;

  assign stat.en = (ww != '0);
  assign stat.x  = wx + col;
  assign stat.y  = wy + row;

  always_ff @(posedge clk) begin
    if (rst) begin
      wx  <= '0;
      wy  <= '0;
      ww  <= '0;
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (cmd.set) begin
      wx  <= cmd.org_x;
      wy  <= cmd.org_y;
      ww  <= (cmd.width == '0) ? fcfw_pkg::COORD_BITS'(1) : cmd.width;
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (cmd.step) begin
      idx <= idx + fcfw_pkg::INDEX_BITS'(1);
      // index wraps to zero: quotient and remainder restart too
      if (idx == '1) begin
        col <= '0;
        row <= '0;
      end else if (col + fcfw_pkg::COORD_BITS'(1) == ww) begin
        col <= '0;
        row <= row + fcfw_pkg::COORD_BITS'(1);
      end else begin
        col <= col + fcfw_pkg::COORD_BITS'(1);
      end
    end
  end

endmodule
`default_nettype wire

[tb/framebuffer_clip_fill_window_writer_unit_tb.sv]
`timescale 1ns / 1ps
`default_nettype none
module framebuffer_clip_fill_window_writer_unit_tb;
  import fcfw_pkg::*;

  // kinds the block leaves unused
  localparam logic [KIND_BITS-1:0] KIND_SPARE_A = 3'd6;
  localparam logic [KIND_BITS-1:0] KIND_SPARE_B = 3'd7;
  localparam int BIG_FILL_AREA = 1024;

  typedef struct packed {
    logic [KIND_BITS-1:0]         kind;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] w;
    logic signed [COORD_BITS-1:0] h;
    logic [COLOR_BITS-1:0]        color;
    logic                         swap;
  } fb_req_t;

  typedef struct packed {
    logic [COLOR_BITS-1:0] color;
    logic [COUNT_BITS-1:0] count;
  } fb_result_t;

  typedef struct packed {
    fb_result_t           res;
    logic [KIND_BITS-1:0] kind;
    int                   seq;
  } pending_t;

  typedef struct packed {
    fb_req_t               req;
    logic                  known;
    logic [COLOR_BITS-1:0] color;
    logic [COUNT_BITS-1:0] count;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] h;
    int                  items;
    logic                max_fill;
  } dims_phase_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int PHASES = 11;

  // known rows hold values that follow directly from reset dimensions 240 x 320
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{KIND_READ,   0,      0,      0,     0,      16'h0000, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_STREAM, 0,      0,      0,     0,      16'h1234, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_PIXEL,  0,      0,      0,     0,      16'hFFFF, 1'b0}, 1'b1, 16'h0000, 19'd1},
    '{'{KIND_PIXEL,  239,    319,    0,     0,      16'hA5A5, 1'b0}, 1'b1, 16'h0000, 19'd1},
    '{'{KIND_PIXEL,  240,    0,      0,     0,      16'h1111, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_PIXEL,  -1,     5,      0,     0,      16'h2222, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_PIXEL,  -32768, 32767,  0,     0,      16'h3333, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_READ,   239,    319,    0,     0,      16'h0000, 1'b0}, 1'b1, 16'hA5A5, 19'd0},
    '{'{KIND_READ,   32767,  -32768, 0,     0,      16'h0000, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_RECT,   -3,     -2,     5,     4,      16'h07E0, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_RECT,   230,    315,    32767, 32767,  16'hF800, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_RECT,   10,     10,     0,     5,      16'h1F1F, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_RECT,   10,     10,     5,     -32768, 16'h1F1F, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_RECT,   -32768, -32768, 32767, 32767,  16'h5555, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_READ,   0,      0,      0,     0,      16'h0000, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_SCREEN, 0,      0,      0,     0,      16'h0F0F, 1'b0}, 1'b1, 16'h0000, 19'd76800},
    '{'{KIND_READ,   120,    160,    0,     0,      16'h0000, 1'b0}, 1'b1, 16'h0F0F, 19'd0},
    '{'{KIND_WINDOW, 5,      6,      0,     7,      16'h0000, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_STREAM, 0,      0,      0,     0,      16'h1234, 1'b1}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_STREAM, 0,      0,      0,     0,      16'hABCD, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_WINDOW, -1,     319,    3,     0,      16'h0000, 1'b0}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_STREAM, 0,      0,      0,     0,      16'hC0DE, 1'b1}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_STREAM, 0,      0,      0,     0,      16'hBEEF, 1'b0}, 1'b0, 16'h0000, 19'd0},
    '{'{KIND_SPARE_A, -1,    -1,     -1,    -1,     16'hFFFF, 1'b1}, 1'b1, 16'h0000, 19'd0},
    '{'{KIND_SPARE_B, -1,    -1,     -1,    -1,     16'hFFFF, 1'b1}, 1'b1, 16'h0000, 19'd0}
  };

  dims_phase_t dims_phases [PHASES] = '{
    '{10'd0,    10'd5,    60,  1'b0},
    '{10'd7,    10'd0,    60,  1'b0},
    '{10'd1,    10'd1,    100, 1'b0},
    '{10'd16,   10'd12,   300, 1'b0},
    '{10'd1023, 10'd1023, 40,  1'b1},
    '{10'd512,  10'd1,    120, 1'b0},
    '{10'd3,    10'd512,  120, 1'b0},
    '{10'd24,   10'd20,   350, 1'b0},
    '{10'd600,  10'd9,    100, 1'b0},
    '{10'd240,  10'd320,  100, 1'b0},
    '{10'd10,   10'd1023, 100, 1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_TDATA-1:0]   s_tdata = '0;
  logic [KIND_BITS-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_TDATA-1:0]  m_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = 1'b0;
  logic [CFG_BITS-1:0]   cfg_data = '0;

  // shadow copy of the block state
  logic [COLOR_BITS-1:0] shadow_frame [DEPTH];
  logic [CFG_BITS-1:0]   buf_w_q;
  logic [CFG_BITS-1:0]   buf_h_q;
  logic [COORD_BITS-1:0] win_x_q;
  logic [COORD_BITS-1:0] win_y_q;
  logic [COORD_BITS-1:0] win_w_q;
  logic [INDEX_BITS-1:0] stream_pos;

  pending_t expected_results [$];
  int       errors = 0;
  int       accepted = 0;
  bit       steady = 1'b0;
  bit       hold_request = 1'b0;
  logic     rx_hold = 1'b0;

  framebuffer_clip_fill_window_writer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int eff_dim(logic [CFG_BITS-1:0] v, int cap);
    return (int'(v) > cap) ? cap : int'(v);
  endfunction

  function automatic fb_result_t predict_request(fb_req_t r);
    int bw, bh, x0, y0, ew, eh, i, j;
    logic [COLOR_BITS-1:0] c;
    logic [COORD_BITS-1:0] sx, sy;
    fb_result_t res;
    bit live;
    bw = eff_dim(buf_w_q, MAX_WIDTH);
    bh = eff_dim(buf_h_q, MAX_HEIGHT);
    live = bw > 0 && bh > 0;
    x0 = $signed(r.x);
    y0 = $signed(r.y);
    ew = $signed(r.w);
    eh = $signed(r.h);
    res = '0;
    case (r.kind)
      KIND_PIXEL: begin
        if (live && x0 >= 0 && y0 >= 0 && x0 < bw && y0 < bh) begin
          shadow_frame[y0 * bw + x0] = r.color;
          res.count = 1;
        end
      end
      KIND_RECT: begin
        if (live && ew >= 1 && eh >= 1) begin
          // negative origin eats into the extent
          if (x0 < 0) begin
            ew += x0;
            x0 = 0;
          end
          if (y0 < 0) begin
            eh += y0;
            y0 = 0;
          end
          if (x0 + ew > bw) ew = bw - x0;
          if (y0 + eh > bh) eh = bh - y0;
          if (ew >= 1 && eh >= 1) begin
            for (j = 0; j < eh; j++)
              for (i = 0; i < ew; i++)
                shadow_frame[(y0 + j) * bw + x0 + i] = r.color;
            res.count = COUNT_BITS'(ew * eh);
          end
        end
      end
      KIND_SCREEN: begin
        if (live) begin
          for (i = 0; i < bw * bh; i++) shadow_frame[i] = r.color;
          res.count = COUNT_BITS'(bw * bh);
        end
      end
      KIND_WINDOW: begin
        win_x_q = r.x;
        win_y_q = r.y;
        win_w_q = (r.w == 0) ? 16'd1 : r.w;
        stream_pos = '0;
      end
      KIND_STREAM: begin
        if (live && win_w_q != 0) begin
          c = r.swap ? {r.color[7:0], r.color[15:8]} : r.color;
          sx = COORD_BITS'(32'(win_x_q) + stream_pos % 32'(win_w_q));
          sy = COORD_BITS'(32'(win_y_q) + stream_pos / 32'(win_w_q));
          stream_pos = stream_pos + 1;
          i = sx;
          j = sy;
          if (i < bw && j < bh) begin
            shadow_frame[j * bw + i] = c;
            res.count = 1;
          end
        end
      end
      KIND_READ: begin
        if (live && x0 >= 0 && y0 >= 0 && x0 < bw && y0 < bh)
          res.color = shadow_frame[y0 * bw + x0];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch: %s", msg);
  endtask

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send(input fb_req_t r, input bit known = 1'b0,
                      input fb_result_t typed = '0);
    int gap;
    pending_t p;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA'({r.swap, r.color, r.h, r.w, r.y, r.x});
    s_tuser  <= r.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    p.res = predict_request(r);
    if (known) p.res = typed;
    p.kind = r.kind;
    p.seq = accepted;
    accepted++;
    expected_results.push_back(p);
  endtask

  // lower valid and let the block run dry before touching the registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    buf_w_q = w;
    cfg_index <= REG_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    buf_h_q = h;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COORD_BITS-1:0] pick_coord(int lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return COORD_BITS'($urandom_range(0, lim));
    if (r < 85) return COORD_BITS'(-$urandom_range(1, 3));
    return COORD_BITS'($urandom);
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_extent(bit wide);
    if (wide && $urandom_range(0, 3) == 0) return COORD_BITS'($urandom);
    return COORD_BITS'(int'($urandom_range(0, 12)) - 2);
  endfunction

  function automatic logic [COLOR_BITS-1:0] pick_color();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return COLOR_BITS'($urandom);
  endfunction

  function automatic fb_req_t random_request(logic [KIND_BITS-1:0] kind);
    fb_req_t r;
    int bw, bh;
    bit wide;
    bw = eff_dim(buf_w_q, MAX_WIDTH);
    bh = eff_dim(buf_h_q, MAX_HEIGHT);
    wide = bw * bh <= BIG_FILL_AREA;
    r.kind  = kind;
    r.x     = pick_coord(bw);
    r.y     = pick_coord(bh);
    r.w     = pick_extent(wide);
    r.h     = pick_extent(wide);
    r.color = pick_color();
    r.swap  = $urandom_range(0, 1);
    if (kind == KIND_WINDOW) begin
      case ($urandom_range(0, 9))
        0: r.w = '0;
        1: r.w = COORD_BITS'($urandom);
        default: r.w = COORD_BITS'($urandom_range(1, bw + 2));
      endcase
      if ($urandom_range(0, 7) == 0) r.x = 16'hFFFF - COORD_BITS'($urandom_range(0, 3));
    end
    if (kind == KIND_STREAM) begin
      r.x = COORD_BITS'($urandom);
      r.y = COORD_BITS'($urandom);
    end
    // fills on a large buffer are slow, keep them to the small ones
    if (!wide && (kind == KIND_RECT && (r.w > 64 || r.h > 64) || kind == KIND_SCREEN))
      r.kind = KIND_READ;
    return r;
  endfunction

  task automatic run_random(input int n);
    int done, r, burst;
    logic [KIND_BITS-1:0] k;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // window followed by a burst of stream pixels
        burst = $urandom_range(1, 12);
        send(random_request(KIND_WINDOW));
        repeat (burst) send(random_request(KIND_STREAM));
        done += burst + 1;
      end else begin
        if (r < 45) k = KIND_PIXEL;
        else if (r < 57) k = KIND_RECT;
        else if (r < 60) k = KIND_SCREEN;
        else if (r < 80) k = KIND_READ;
        else if (r < 86) k = KIND_STREAM;
        else if (r < 90) k = KIND_WINDOW;
        else if (r < 95) k = KIND_BITS'($urandom);
        else k = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
        send(random_request(k));
        done++;
      end
    end
  endtask

  task automatic check_result(input logic [OUT_TDATA-1:0] data);
    pending_t p;
    logic [COLOR_BITS-1:0] got_color;
    logic [COUNT_BITS-1:0] got_count;
    got_color = data[COLOR_BITS-1:0];
    got_count = data[COLOR_BITS +: COUNT_BITS];
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result %h with no request outstanding", data));
    end else begin
      p = expected_results.pop_front();
      if (got_color !== p.res.color || got_count !== p.res.count)
        report_mismatch($sformatf("request %0d kind %0d: color %h count %0d, want %h %0d",
                                  p.seq, p.kind, got_color, got_count,
                                  p.res.color, p.res.count));
    end
  endtask

  always @(posedge clk) begin : result_side
    int r;
    int stall_left;
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (rx_hold) begin
      m_tready <= 1'b0;
    end else if (steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_tready <= 1'b1;
      end else begin
        if (r < 90) stall_left = $urandom_range(0, 2);
        else if (r < 97) stall_left = $urandom_range(3, 12);
        else stall_left = $urandom_range(20, 50);
        m_tready <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int i;
    for (i = 0; i < DEPTH; i++) shadow_frame[i] = '0;
    buf_w_q = WIDTH_RESET;
    buf_h_q = HEIGHT_RESET;
    win_x_q = '0;
    win_y_q = '0;
    win_w_q = '0;
    stream_pos = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIRECTED_ROWS; i++)
      send(directed_rows[i].req, directed_rows[i].known,
           '{directed_rows[i].color, directed_rows[i].count});

    for (i = 0; i < PHASES; i++) begin
      wait_idle();
      set_dims(dims_phases[i].w, dims_phases[i].h);
      steady = ($urandom_range(0, 3) == 0);
      if (i == 3) hold_request = 1'b1;
      if (dims_phases[i].max_fill) begin
        send('{KIND_SCREEN, 0, 0, 0, 0, pick_color(), 1'b0});
        send('{KIND_READ, 511, 511, 0, 0, 16'h0000, 1'b0});
      end
      run_random(dims_phases[i].items);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
